// File: sv/fan_speed_kickstart_stall_monitor_top_assert.svh
// ----------------------------------------------------------------------------
// Fan monitor assertion macros
// Shorthand for the concurrent checks of the fan monitor top level.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_KICKSTART_STALL_MONITOR_TOP_ASSERT_SVH
`define FAN_SPEED_KICKSTART_STALL_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FSKSM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define FSKSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fsksm_pkg.sv
// ----------------------------------------------------------------------------
// Fan monitor package
// Constants, register codes, field positions and shared types.
// ----------------------------------------------------------------------------
package fsksm_pkg;

    localparam int OUTQ_DEPTH_DEF = 4;

    localparam logic [16:0] FULL_SCALE = 17'd65536;
    localparam logic [17:0] HALF_SCALE = 18'd32768;
    localparam logic [2:0]  MISS_LIMIT = 3'd6;
    localparam logic [15:0] KICK_RESET = 16'd100;

    // configuration register indexes
    localparam logic [1:0] REG_DUTY_CEIL      = 2'd0;
    localparam logic [1:0] REG_OFF_LEVEL      = 2'd1;
    localparam logic [1:0] REG_KICK_TICKS     = 2'd2;
    localparam logic [1:0] REG_ENABLE_PRESENT = 2'd3;

    localparam logic ACT_SPEED  = 1'b0;
    localparam logic ACT_TICK   = 1'b1;
    localparam logic KIND_DUTY  = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // stream field layout
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;
    localparam int IN_SPEED_LO = 0;
    localparam int IN_SPIN     = 17;
    localparam int IN_TIME_LO  = 18;
    localparam int OUT_DUTY_LO = 0;
    localparam int OUT_EN      = 17;
    localparam int OUT_HOLD_LO = 18;
    localparam int OUT_TIME_LO = 34;
    localparam int OUT_FNEW    = 66;
    localparam int OUT_ERR_LO  = 67;

    typedef struct packed {
        logic [16:0] duty_ceil;
        logic [16:0] off_level;
        logic [15:0] kick_ticks;
        logic        enable_present;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic        speed_nz;
        logic        spin;
        logic [17:0] prod;
        logic [31:0] apply_time;
    } t_work;

    typedef struct packed {
        logic        kind;
        logic [16:0] duty;
        logic        enable_level;
        logic [15:0] hold_ticks;
        logic [31:0] apply_time;
        logic        last;
        logic        fault_new;
        logic [2:0]  error_count;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

// File: sv/fsksm_eval.sv
// ----------------------------------------------------------------------------
// Fan monitor evaluation stage
// Holds duty and stall-check state and forms the results of one item.
// ----------------------------------------------------------------------------
module fsksm_eval (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fsksm_pkg::t_cfg       i_cfg,
    input  logic                  i_fire,
    input  fsksm_pkg::t_work      i_work,
    output fsksm_pkg::t_push      o_push
);

    // duty_now doubles as the requested duty: both always change together
    logic [16:0] r_duty_now;
    logic [2:0]  r_miss;
    logic        r_fault;
    logic        r_monitor;

    logic [16:0] w_target;
    logic        w_changed;
    logic        w_big_rise;
    logic        w_kick;
    logic        w_second;
    logic [2:0]  w_miss_req;
    logic        w_match;
    logic [2:0]  w_miss_inc;
    logic        w_over;
    logic [2:0]  w_miss_tick;
    logic        w_fault_tick;
    logic        w_fnew;

    always_comb begin
        w_target   = (i_work.prod > {1'b0, i_cfg.duty_ceil}) ? i_cfg.duty_ceil
                                                              : i_work.prod[16:0];
        w_changed  = (w_target != r_duty_now);
        w_big_rise = ({1'b0, w_target} > ({1'b0, r_duty_now} + fsksm_pkg::HALF_SCALE));
        w_kick     = (w_target != 17'd0) && (i_cfg.kick_ticks != 16'd0) &&
                     ((r_duty_now == 17'd0) || w_big_rise);
        w_second   = (w_target != i_cfg.duty_ceil);
        w_miss_req = i_work.speed_nz ? 3'd0 : r_miss;

        w_match      = ((r_duty_now != 17'd0) == i_work.spin);
        w_miss_inc   = r_miss + 3'd1;
        w_over       = !w_match && (w_miss_inc > fsksm_pkg::MISS_LIMIT);
        w_miss_tick  = w_match ? 3'd0 : (w_over ? fsksm_pkg::MISS_LIMIT : w_miss_inc);
        w_fnew       = w_over && !r_fault;
        w_fault_tick = w_match ? 1'b0 : (w_over ? 1'b1 : r_fault);
    end

    always_comb begin
        o_push = '0;
        if (i_work.action == fsksm_pkg::ACT_SPEED) begin
            o_push.r0.kind        = fsksm_pkg::KIND_DUTY;
            o_push.r0.apply_time  = i_work.apply_time;
            o_push.r0.error_count = w_miss_req;
            o_push.r1             = o_push.r0;
            o_push.r1.duty        = w_target;
            o_push.r1.last        = 1'b1;
            if (w_changed) begin
                if (w_kick) begin
                    o_push.r0.duty       = i_cfg.duty_ceil;
                    o_push.r0.hold_ticks = i_cfg.kick_ticks;
                    o_push.r0.last       = !w_second;
                    o_push.num           = w_second ? 2'd2 : 2'd1;
                end else begin
                    o_push.r0.duty = w_target;
                    o_push.r0.last = 1'b1;
                    o_push.num     = 2'd1;
                end
            end
        end else if (r_monitor) begin
            o_push.r0.kind        = fsksm_pkg::KIND_CHECK;
            o_push.r0.duty        = r_duty_now;
            o_push.r0.last        = 1'b1;
            o_push.r0.fault_new   = w_fnew;
            o_push.r0.error_count = w_miss_tick;
            o_push.num            = 2'd1;
        end
        o_push.r0.enable_level = i_cfg.enable_present && (o_push.r0.duty != 17'd0);
        o_push.r1.enable_level = i_cfg.enable_present && (o_push.r1.duty != 17'd0);
        if (!i_fire) begin
            o_push.num = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_now <= '0;
            r_miss     <= '0;
            r_fault    <= 1'b0;
            r_monitor  <= 1'b0;
        end else if (i_fire) begin
            if (i_work.action == fsksm_pkg::ACT_SPEED) begin
                if (w_changed) begin
                    r_duty_now <= w_target;
                end
                r_monitor <= i_work.speed_nz;
                if (i_work.speed_nz) begin
                    r_miss  <= 3'd0;
                    r_fault <= 1'b0;
                end
            end else if (r_monitor) begin
                r_miss  <= w_miss_tick;
                r_fault <= w_fault_tick;
            end
        end
    end

endmodule

// File: sv/fsksm_outq.sv
// ----------------------------------------------------------------------------
// Fan monitor result queue
// Small register queue taking up to two results a cycle, one out a cycle when popped.
// ----------------------------------------------------------------------------
module fsksm_outq #(
    parameter int DEPTH = fsksm_pkg::OUTQ_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsksm_pkg::t_push              i_push,
    input  logic                          i_pop,
    output logic                          o_valid,
    output fsksm_pkg::t_result            o_head,
    output logic [$clog2(DEPTH+1)-1:0]    o_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    fsksm_pkg::t_result r_q [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wp;
    logic [PW-1:0] n_rp;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp + PW'(i_push.num);
        n_rp  = r_rp + PW'(i_pop);
        n_cnt = r_cnt + CW'(i_push.num) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.num == 2'd2) begin
            r_q[r_wp + PW'(1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[r_rp];
    assign o_level = r_cnt;

endmodule

// File: sv/fan_speed_kickstart_stall_monitor_top.sv
// ----------------------------------------------------------------------------
// Fan speed kick-start and stall monitor
// PWM duty scaling with kick-start and tachometer stall counting, Q1.16.
// ----------------------------------------------------------------------------
//  port group   dir  tdata fields (low bit up)                        tuser   tlast
//  s_axis       in   speed, tach_spinning, apply_time                 action  -
//  m_axis       out  duty, enable_level, hold_ticks, apply_time_out,  kind    last
//                    fault_new, error_count
//  i_cfg_*      in   write enable, index, data                        -       -
//
//  An item is taken every cycle while the result queue has room. The first
//  result reaches m_axis through the input register, the multiply register and
//  the result queue. A kick-start request yields up to two results, and these
//  leave one at a time through the one port. A stalled output holds its item;
//  input stalls once the queue cannot hold two. Reset (synchronous, i_rst_n low)
//  clears control, configuration and fan state, not the data; no clearing pass.
// ----------------------------------------------------------------------------
module fan_speed_kickstart_stall_monitor_top #(
    parameter int OUTQ_DEPTH = fsksm_pkg::OUTQ_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // speed[16:0], tach_spinning[17], apply_time[49:18], zero fill above
    input  logic [fsksm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // duty[16:0], enable_level[17], hold_ticks[33:18], apply_time_out[65:34],
    // fault_new[66], error_count[69:67], zero fill above
    output logic [fsksm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // kind
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [16:0]                         i_cfg_wdata
);

    `include "fan_speed_kickstart_stall_monitor_top_assert.svh"

    localparam int CW = $clog2(OUTQ_DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(OUTQ_DEPTH - 2);

    fsksm_pkg::t_cfg    r_cfg;
    logic               r_a_v;
    logic               r_a_action;
    logic [16:0]        r_a_speed;
    logic               r_a_spin;
    logic [31:0]        r_a_time;
    logic               r_b_v;
    fsksm_pkg::t_work   r_b;

    logic               w_in_acc;
    logic               w_fire;
    logic               w_b_load;
    logic [16:0]        w_req;
    logic [33:0]        w_product;
    logic [CW-1:0]      w_level;
    logic               w_pop;
    fsksm_pkg::t_push   w_push;
    fsksm_pkg::t_result w_head;
    logic               w_err_ok;
    logic               w_out_fnew;
    logic               w_fault_ok;
    logic               w_out_mid;
    logic               w_kick_ok;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_ceil      <= fsksm_pkg::FULL_SCALE;
            r_cfg.off_level      <= '0;
            r_cfg.kick_ticks     <= fsksm_pkg::KICK_RESET;
            r_cfg.enable_present <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fsksm_pkg::REG_DUTY_CEIL:      r_cfg.duty_ceil      <= i_cfg_wdata;
                fsksm_pkg::REG_OFF_LEVEL:      r_cfg.off_level      <= i_cfg_wdata;
                fsksm_pkg::REG_KICK_TICKS:     r_cfg.kick_ticks     <= i_cfg_wdata[15:0];
                fsksm_pkg::REG_ENABLE_PRESENT: r_cfg.enable_present <= i_cfg_wdata[0];
                default:                       r_cfg                <= r_cfg;
            endcase
        end
    end

    assign w_fire        = r_b_v && (w_level <= ROOM_MAX);
    assign w_b_load      = !r_b_v || w_fire;
    assign s_axis_tready = !r_a_v || w_b_load;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_in_acc) begin
            r_a_v <= 1'b1;
        end else if (w_b_load) begin
            r_a_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_action <= s_axis_tuser;
            r_a_speed  <= s_axis_tdata[fsksm_pkg::IN_SPEED_LO +: 17];
            r_a_spin   <= s_axis_tdata[fsksm_pkg::IN_SPIN];
            r_a_time   <= s_axis_tdata[fsksm_pkg::IN_TIME_LO +: 32];
        end
    end

    // threshold and scale by the duty ceiling, truncating
    always_comb begin
        w_req     = (r_a_speed < r_cfg.off_level) ? 17'd0 : r_a_speed;
        w_product = w_req * r_cfg.duty_ceil;
    end

    // multiply register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_b_load) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_load) begin
            r_b.action     <= r_a_action;
            r_b.speed_nz   <= (r_a_speed != 17'd0);
            r_b.spin       <= r_a_spin;
            r_b.prod       <= w_product[33:16];
            r_b.apply_time <= r_a_time;
        end
    end

    fsksm_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_fire  (w_fire),
        .i_work  (r_b),
        .o_push  (w_push)
    );

    assign w_pop = m_axis_tvalid && m_axis_tready;

    fsksm_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_head  (w_head),
        .o_level (w_level)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[fsksm_pkg::OUT_DUTY_LO +: 17] = w_head.duty;
        m_axis_tdata[fsksm_pkg::OUT_EN]            = w_head.enable_level;
        m_axis_tdata[fsksm_pkg::OUT_HOLD_LO +: 16] = w_head.hold_ticks;
        m_axis_tdata[fsksm_pkg::OUT_TIME_LO +: 32] = w_head.apply_time;
        m_axis_tdata[fsksm_pkg::OUT_FNEW]          = w_head.fault_new;
        m_axis_tdata[fsksm_pkg::OUT_ERR_LO +: 3]   = w_head.error_count;
    end
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

    assign w_err_ok   = (w_head.error_count <= fsksm_pkg::MISS_LIMIT);
    assign w_out_fnew = m_axis_tvalid && w_head.fault_new;
    assign w_fault_ok = (w_head.kind == fsksm_pkg::KIND_CHECK) &&
                        (w_head.error_count == fsksm_pkg::MISS_LIMIT);
    assign w_out_mid  = m_axis_tvalid && !m_axis_tlast;
    assign w_kick_ok  = (w_head.kind == fsksm_pkg::KIND_DUTY) &&
                        (w_head.duty == r_cfg.duty_ceil) && (w_head.hold_ticks != 16'd0);

    `FSKSM_ASSERT_IMPL(a_queue_bound, 1'b1, w_level <= CW'(OUTQ_DEPTH), "result queue overrun")
    `FSKSM_ASSERT_IMPL(a_err_held, m_axis_tvalid, w_err_ok, "miss count above limit")
    `FSKSM_ASSERT_IMPL(a_fault_check, w_out_fnew, w_fault_ok, "fault outside a saturated check")
    `FSKSM_ASSERT_IMPL(a_kick_first, w_out_mid, w_kick_ok, "non-last result is not a kick")
    `FSKSM_ASSERT_NEXT(a_kick_pair, w_push.num == 2'd2, w_level >= CW'(2), "kick pair not queued")

endmodule

// File: verif/fan_speed_kickstart_stall_monitor_top_tb.sv
// ----------------------------------------------------------------------------
// Fan monitor top level testbench
// Streams speed requests and tachometer check ticks into the fan monitor with
// random stalls on both sides. A cycle-free predictor of the duty scaling,
// kick-start and stall counting builds the expected results, and a monitor
// compares every result field by field. Configuration changes between phases.
// ----------------------------------------------------------------------------
module fan_speed_kickstart_stall_monitor_top_tb;

    typedef struct {
        logic        act;
        logic [16:0] spd;
        logic        spin;
        logic [31:0] at;
    } t_fan_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [fsksm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tuser = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [fsksm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              i_cfg_we = 1'b0;
    logic [1:0]                        i_cfg_addr = '0;
    logic [16:0]                       i_cfg_wdata = '0;

    fan_speed_kickstart_stall_monitor_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // configuration copy and fan state of the predictor
    logic [16:0] cfg_duty_ceil = fsksm_pkg::FULL_SCALE;
    logic [16:0] cfg_off_level = 17'd0;
    logic [15:0] cfg_kick_ticks = fsksm_pkg::KICK_RESET;
    logic        cfg_en_present = 1'b0;
    logic [16:0] pwm_duty = 17'd0;
    logic [16:0] req_duty = 17'd0;
    logic [2:0]  miss_cnt = 3'd0;
    logic        fault_seen = 1'b0;
    logic        watching = 1'b0;

    t_fan_cmd           pend_q[$];
    t_fan_cmd           next_cmd;
    fsksm_pkg::t_result duty_expect_q[$];
    fsksm_pkg::t_result want_r;
    int                 issued = 0;
    int                 taken = 0;
    int                 fail_cnt = 0;
    logic               steady_tail = 1'b0;
    int                 gap_left = 0;
    int                 calm_left = 0;
    int                 stall_left = 0;
    int                 rcalm_left = 0;

    function automatic fsksm_pkg::t_result duty_result(input logic kind,
                                                       input logic [16:0] duty,
                                                       input logic [15:0] hold,
                                                       input logic [31:0] at,
                                                       input logic lst);
        fsksm_pkg::t_result r;
        r.kind = kind;
        r.duty = duty;
        r.enable_level = cfg_en_present && (duty != 17'd0);
        r.hold_ticks = hold;
        r.apply_time = at;
        r.last = lst;
        r.fault_new = 1'b0;
        r.error_count = 3'd0;
        return r;
    endfunction

    task automatic predict_fan(input logic act, input logic [16:0] spd,
                               input logic spin, input logic [31:0] at);
        logic [16:0]        req;
        logic [33:0]        prod;
        logic [16:0]        target;
        fsksm_pkg::t_result res [2];
        int                 n;
        int                 k;
        logic               fnew;
        n = 0;
        fnew = 1'b0;
        if (act == fsksm_pkg::ACT_SPEED) begin
            req = (spd < cfg_off_level) ? 17'd0 : spd;
            prod = ({17'd0, req} * {17'd0, cfg_duty_ceil}) >> 16;
            target = (prod > {17'd0, cfg_duty_ceil}) ? cfg_duty_ceil : prod[16:0];
            if (target != pwm_duty) begin
                if (target != 17'd0 && cfg_kick_ticks != 16'd0 &&
                    (pwm_duty == 17'd0 ||
                     int'(target) - int'(pwm_duty) > int'(fsksm_pkg::HALF_SCALE))) begin
                    // kick at the duty ceiling first; skip the second item if it repeats
                    res[0] = duty_result(fsksm_pkg::KIND_DUTY, cfg_duty_ceil, cfg_kick_ticks,
                                         at, target == cfg_duty_ceil);
                    n = 1;
                    if (target != cfg_duty_ceil) begin
                        res[1] = duty_result(fsksm_pkg::KIND_DUTY, target, 16'd0, at, 1'b1);
                        n = 2;
                    end
                end else begin
                    res[0] = duty_result(fsksm_pkg::KIND_DUTY, target, 16'd0, at, 1'b1);
                    n = 1;
                end
                pwm_duty = target;
                req_duty = target;
            end
            if (spd != 17'd0) begin
                watching = 1'b1;
                miss_cnt = 3'd0;
                fault_seen = 1'b0;
            end else begin
                watching = 1'b0;
            end
            for (k = 0; k < n; k++) begin
                res[k].error_count = miss_cnt;
                duty_expect_q.push_back(res[k]);
            end
        end else if (watching) begin
            if ((req_duty != 17'd0) == spin) begin
                miss_cnt = 3'd0;
                fault_seen = 1'b0;
            end else begin
                miss_cnt = miss_cnt + 3'd1;
            end
            if (miss_cnt > fsksm_pkg::MISS_LIMIT) begin
                if (!fault_seen) begin
                    fnew = 1'b1;
                    fault_seen = 1'b1;
                end
                miss_cnt = fsksm_pkg::MISS_LIMIT;
            end
            res[0] = duty_result(fsksm_pkg::KIND_CHECK, pwm_duty, 16'd0, 32'd0, 1'b1);
            res[0].fault_new = fnew;
            res[0].error_count = miss_cnt;
            duty_expect_q.push_back(res[0]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // input acceptance and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (duty_expect_q.size() == 0) begin
                    $error("unexpected result: kind %0d duty %0d", m_axis_tuser,
                           m_axis_tdata[fsksm_pkg::OUT_DUTY_LO +: 17]);
                    fail_cnt++;
                end else begin
                    want_r = duty_expect_q.pop_front();
                    check_field("kind", 32'(want_r.kind), 32'(m_axis_tuser));
                    check_field("duty", 32'(want_r.duty),
                                32'(m_axis_tdata[fsksm_pkg::OUT_DUTY_LO +: 17]));
                    check_field("enable_level", 32'(want_r.enable_level),
                                32'(m_axis_tdata[fsksm_pkg::OUT_EN]));
                    check_field("hold_ticks", 32'(want_r.hold_ticks),
                                32'(m_axis_tdata[fsksm_pkg::OUT_HOLD_LO +: 16]));
                    check_field("apply_time_out", want_r.apply_time,
                                m_axis_tdata[fsksm_pkg::OUT_TIME_LO +: 32]);
                    check_field("last", 32'(want_r.last), 32'(m_axis_tlast));
                    check_field("fault_new", 32'(want_r.fault_new),
                                32'(m_axis_tdata[fsksm_pkg::OUT_FNEW]));
                    check_field("error_count", 32'(want_r.error_count),
                                32'(m_axis_tdata[fsksm_pkg::OUT_ERR_LO +: 3]));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_fan(s_axis_tuser, s_axis_tdata[fsksm_pkg::IN_SPEED_LO +: 17],
                            s_axis_tdata[fsksm_pkg::IN_SPIN],
                            s_axis_tdata[fsksm_pkg::IN_TIME_LO +: 32]);
                taken <= taken + 1;
            end
        end
    end

    // input driver: hold an item until taken, then gap or present the next
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || issued == taken) begin
            if (calm_left != 0)
                calm_left <= calm_left - 1;
            if (!steady_tail && gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pend_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (!steady_tail && calm_left == 0 && $urandom_range(0, 4) == 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= $urandom_range(0, 5);
                if ($urandom_range(0, 7) == 0)
                    calm_left <= $urandom_range(20, 60);
            end else begin
                next_cmd = pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= next_cmd.act;
                s_axis_tdata <= {{(fsksm_pkg::IN_TDATA_W-50){1'b0}}, next_cmd.at,
                                 next_cmd.spin, next_cmd.spd};
                issued <= issued + 1;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (steady_tail) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rcalm_left != 0) begin
            m_axis_tready <= 1'b1;
            rcalm_left <= rcalm_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 5);
            if ($urandom_range(0, 7) == 0)
                rcalm_left <= $urandom_range(20, 60);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic queue_cmd(input logic act, input logic [16:0] spd, input logic spin,
                             input logic [31:0] at);
        t_fan_cmd c;
        c.act = act;
        c.spd = spd;
        c.spin = spin;
        c.at = at;
        pend_q.push_back(c);
    endtask

    function automatic logic [16:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return fsksm_pkg::FULL_SCALE;
            2: return 17'($urandom_range(65537, 131071));
            3: return (cfg_off_level == 17'd0) ? 17'd0 : cfg_off_level - 17'd1;
            4: return cfg_off_level;
            5, 6: return 17'($urandom_range(1, 3000));
            default: return 17'($urandom);
        endcase
    endfunction

    // mostly a request followed by a run of ticks whose spin level rarely flips
    task automatic queue_random(input int n_items);
        int   cnt;
        int   run;
        logic spin;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_cmd(fsksm_pkg::ACT_SPEED, pick_speed(), 1'($urandom), $urandom);
                run = $urandom_range(0, 10);
                spin = 1'($urandom);
                repeat (run)
                    queue_cmd(fsksm_pkg::ACT_TICK, 17'($urandom),
                              ($urandom_range(0, 9) == 0) ? ~spin : spin, $urandom);
                cnt += run + 1;
            end else begin
                queue_cmd(1'($urandom), 17'($urandom), 1'($urandom), $urandom);
                cnt++;
            end
        end
    endtask

    // hold until every item is taken and every result is in, then let the pipe settle
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((pend_q.size() != 0 || s_axis_tvalid || duty_expect_q.size() != 0) &&
               waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [16:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        case (idx)
            fsksm_pkg::REG_DUTY_CEIL:      cfg_duty_ceil = val;
            fsksm_pkg::REG_OFF_LEVEL:      cfg_off_level = val;
            fsksm_pkg::REG_KICK_TICKS:     cfg_kick_ticks = val[15:0];
            fsksm_pkg::REG_ENABLE_PRESENT: cfg_en_present = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_fan(input logic [16:0] ceil_v, input logic [16:0] off_v,
                               input logic [15:0] kick, input logic en);
        wait_drained();
        set_reg(fsksm_pkg::REG_DUTY_CEIL, ceil_v);
        set_reg(fsksm_pkg::REG_OFF_LEVEL, off_v);
        set_reg(fsksm_pkg::REG_KICK_TICKS, {1'b0, kick});
        set_reg(fsksm_pkg::REG_ENABLE_PRESENT, {16'd0, en});
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: tick while unmonitored, capped request, kick paths
        queue_cmd(fsksm_pkg::ACT_TICK, 17'd0, 1'b0, 32'd0);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'h1FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_cmd(fsksm_pkg::ACT_SPEED, fsksm_pkg::FULL_SCALE, 1'b0, 32'h1234_5678);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'd40000, 1'b0, 32'h0000_0001);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'd0, 1'b0, 32'h8000_0000);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'd1, 1'b1, 32'd0);
        // stalled fan: count up, hold at the limit, flag the fault once
        repeat (8) queue_cmd(fsksm_pkg::ACT_TICK, 17'h1FFFF, 1'b0, 32'hFFFF_FFFF);
        queue_cmd(fsksm_pkg::ACT_TICK, 17'd0, 1'b1, 32'd7);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'd20000, 1'b0, 32'hDEAD_BEEF);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'd60000, 1'b0, 32'h0F0F_0F0F);
        queue_cmd(fsksm_pkg::ACT_SPEED, 17'd0, 1'b1, 32'hF0F0_F0F0);
        queue_cmd(fsksm_pkg::ACT_TICK, 17'd0, 1'b1, 32'd0);

        program_fan(fsksm_pkg::FULL_SCALE, 17'd0, fsksm_pkg::KICK_RESET, 1'b1);
        queue_random(120);
        program_fan(17'd0, fsksm_pkg::FULL_SCALE, 16'd0, 1'b0);
        queue_random(100);
        program_fan(fsksm_pkg::FULL_SCALE, fsksm_pkg::FULL_SCALE, 16'hFFFF, 1'b1);
        queue_random(100);
        program_fan(17'd1, 17'd1, 16'd1, 1'b1);
        queue_random(100);
        repeat (3) begin
            program_fan(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 40000)),
                        ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom), 1'($urandom));
            queue_random(110);
        end
        program_fan(17'($urandom_range(1, 65536)), 17'($urandom_range(0, 20000)),
                    16'($urandom_range(1, 65535)), 1'($urandom));
        steady_tail = 1'b1;
        queue_random(100);

        wait_drained();
        repeat (12) @(posedge i_clk);
        if (duty_expect_q.size() != 0) begin
            $error("%0d expected results never arrived", duty_expect_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("fan_speed_kickstart_stall_monitor_top_tb: clean");
        else
            $display("fan_speed_kickstart_stall_monitor_top_tb: errors");
        $finish;
    end

    initial begin
        #3000000;
        $display("fan_speed_kickstart_stall_monitor_top_tb: errors");
        $finish;
    end

endmodule
